@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// ils_pkg
// Types and constants of the integer list sorter.
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int unsigned MAX_ELEMENTS_DEF = 64;
   localparam int unsigned VALUE_W          = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   // Input word: one list element
   typedef struct packed {
      value_type value;
      logic      is_last;
   } req_word_type;

   // Result word: one sorted element
   typedef struct packed {
      value_type sorted_value;
      logic      end_of_list;
      logic      overflow;
   } rsp_word_type;

   // Controller to datapath commands
   typedef struct packed {
      logic insert;      // store the input word into the chain
      logic drop;        // discard the input word, chain is full
      logic shift;       // move the chain one place toward the read end
      logic emit;        // register the read end as a result word
      logic finish;      // last word of the burst, clear list state
      logic descending;  // read from the top end, shifting up
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic full;        // chain holds the maximum number of elements
      logic end_valid;   // the selected read end holds an element
      logic last_one;    // one element remains to be emitted
   } sts_type;

endpackage

@@ hw/rtl/ils_ctrl.sv @@
// ----------------------------------------------------------------------------
// ils_ctrl
// Controller: collects words, then runs the emission burst.
// ----------------------------------------------------------------------------
module ils_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 is_last,
   input  logic                 sort_order,
   input  ils_pkg::sts_type     sts,
   output logic                 busy,
   output ils_pkg::cmd_type     cmd
);
   import ils_pkg::*;

   typedef enum logic {
      ST_COLLECT,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy   = (state_ff == ST_EMIT);
   assign accept = start & ~busy;

   // Decode commands for the datapath
   always_comb begin
      cmd            = '0;
      cmd.insert     = accept & ~sts.full;
      cmd.drop       = accept & sts.full;
      cmd.shift      = busy;
      cmd.emit       = busy & sts.end_valid;
      cmd.finish     = busy & sts.end_valid & sts.last_one;
      cmd.descending = sort_order;
   end

   // Advance between collecting and emitting
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (accept && is_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.finish) begin
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/ils_dp.sv @@
// ----------------------------------------------------------------------------
// ils_dp
// Datapath: insertion cell chain kept in ascending order, element counter,
// overflow flag and the result register.
// ----------------------------------------------------------------------------
module ils_dp #(
   parameter int unsigned MAX_ELEMENTS = ils_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ils_pkg::value_type    in_value,
   input  ils_pkg::cmd_type      cmd,
   output ils_pkg::sts_type      sts,
   output logic                  rsp_valid,
   output ils_pkg::rsp_word_type rsp_word
);
   import ils_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

   value_type               cell_ff  [MAX_ELEMENTS];
   value_type               cell_in  [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] valid_ff;
   logic [MAX_ELEMENTS-1:0] valid_in;
   logic [MAX_ELEMENTS-1:0] after;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    ovf_ff;
   logic                    ovf_in;
   logic                    rsp_valid_ff;
   rsp_word_type            rsp_word_ff;
   rsp_word_type            rsp_word_in;

   // Compare every cell with the incoming value; empty cells sort last
   always_comb begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         after[i] = ~valid_ff[i] | (cell_ff[i] > in_value);
      end
   end

   // Next value of each cell: insert, shift toward the read end, or hold
   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      value_type below_val;
      value_type above_val;
      logic      below_vld;
      logic      above_vld;
      logic      below_after;

      if (i == 0) begin : g_bottom
         assign below_val   = cell_ff[i];
         assign below_vld   = 1'b0;
         assign below_after = 1'b0;
      end else begin : g_inner_lo
         assign below_val   = cell_ff[i-1];
         assign below_vld   = valid_ff[i-1];
         assign below_after = after[i-1];
      end

      if (i == MAX_ELEMENTS - 1) begin : g_top
         assign above_val = cell_ff[i];
         assign above_vld = 1'b0;
      end else begin : g_inner_hi
         assign above_val = cell_ff[i+1];
         assign above_vld = valid_ff[i+1];
      end

      always_comb begin
         cell_in[i]  = cell_ff[i];
         valid_in[i] = valid_ff[i];
         priority if (cmd.insert) begin
            if (after[i]) begin
               cell_in[i] = below_after ? below_val : in_value;
            end
            valid_in[i] = (i == 0) ? 1'b1 : (valid_ff[i] | below_vld);
         end else if (cmd.shift) begin
            cell_in[i]  = cmd.descending ? below_val : above_val;
            valid_in[i] = cmd.descending ? below_vld : above_vld;
         end else begin
            cell_in[i]  = cell_ff[i];
            valid_in[i] = valid_ff[i];
         end
      end
   end

   // Status for the controller
   always_comb begin
      sts           = '0;
      sts.full      = (count_ff == CNT_W'(MAX_ELEMENTS));
      sts.end_valid = cmd.descending ? valid_ff[MAX_ELEMENTS-1] : valid_ff[0];
      sts.last_one  = (count_ff == CNT_W'(1));
   end

   // Count stored elements, drop one per emitted word
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff | cmd.drop;
      priority if (cmd.finish) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.emit) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // Form the result word from the selected read end
   always_comb begin
      rsp_word_in              = '0;
      rsp_word_in.sorted_value = cmd.descending ? cell_ff[MAX_ELEMENTS-1] : cell_ff[0];
      rsp_word_in.end_of_list  = sts.last_one;
      rsp_word_in.overflow     = ovf_ff;
   end

   // Hold chain payload
   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (cmd.emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ hw/rtl/integer_list_sorter_top.sv @@
// ----------------------------------------------------------------------------
// integer_list_sorter_top
// Sorts a list of signed 32-bit words, ascending or descending.
// ----------------------------------------------------------------------------
// Words are taken one per cycle while busy is low: each is inserted into an
// ascending cell chain in the cycle it arrives, and words beyond
// MAX_ELEMENTS are dropped and flag overflow on every result of that list.
// The word marked is_last raises busy and starts the burst; the receiver
// cannot stall, so results come out on rsp_valid strobes. Ascending: n
// results back to back, the first once the state register enters the burst
// and the result register has taken cell 0. Descending: the chain shifts up
// toward its top cell, so the first result follows once the largest element
// reaches the top cell, and the burst then runs back to back. The chain
// shifts one place per cycle in the burst. busy falls in the cycle that
// carries end_of_list. The sort order register is read during the burst.
// ----------------------------------------------------------------------------
module integer_list_sorter_top #(
   parameter int unsigned MAX_ELEMENTS = ils_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ils_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output ils_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic                  csr_wdata
);
   import ils_pkg::*;

   logic    sort_order_ff;
   cmd_type cmd;
   sts_type sts;

   // Hold the sort order register
   always_ff @(posedge clock) begin
      if (reset) begin
         sort_order_ff <= 1'b0;
      end else if (csr_we) begin
         sort_order_ff <= csr_wdata;
      end
   end

   ils_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .is_last    (req_word.is_last),
      .sort_order (sort_order_ff),
      .sts        (sts),
      .busy       (busy),
      .cmd        (cmd)
   );

   ils_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .in_value  (req_word.value),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

@@ hw/rtl/ils_checker.sv @@
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks of the sorter burst, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ils_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input ils_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input ils_pkg::rsp_word_type rsp_word
);
   import ils_pkg::*;

   logic take_last;
   logic more_due;
   logic last_out;

   assign take_last = start && !busy && req_word.is_last;
   assign more_due  = rsp_valid && !rsp_word.end_of_list;
   assign last_out  = rsp_valid && rsp_word.end_of_list;

   // A marked word starts the burst
   `ASSERT_NEXT(a_last_starts_burst, clock, reset, take_last, busy, "busy not raised")

   // The burst ends only with the end-of-list word
   `ASSERT_SAME(a_busy_falls_at_end, clock, reset, $fell(busy), last_out, "busy fell early")

   // A word that is not the last is followed by the next one
   `ASSERT_NEXT(a_burst_continues, clock, reset, more_due, rsp_valid, "burst stopped early")

   // Results appear only out of a burst
   `ASSERT_SAME(a_result_in_burst, clock, reset, rsp_valid, $past(busy), "result outside a burst")

endmodule

bind integer_list_sorter_top ils_checker u_ils_checker (.*);
